/* rtl/mipds_pkg.sv */
// shared types, constants and the srgb decode table of the 2x2 mipmap reducer
`default_nettype none

package mipds_pkg;

    localparam int LIN_BITS        = 16;
    localparam int MAX_CHANNELS    = 4;
    localparam int NUM_CH          = 4;
    localparam int CH_W            = 8;
    localparam int PIX_W           = NUM_CH * CH_W;
    localparam int PAIR_W          = 2 * PIX_W;
    localparam int MAX_FINE_HEIGHT = 4096;
    localparam int ROW_W           = 12;
    localparam int HGT_W           = ROW_W + 1;
    localparam int CFG_W           = 13;
    localparam int CFG_IDX_W       = 2;
    localparam int CNT_W           = 3;
    localparam int ENC_STAGES      = CH_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_SRGB_MODE     = 2'd1,
        CFG_FINE_WIDTH    = 2'd2,
        CFG_FINE_HEIGHT   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              row_end;
        logic              image_end;
        logic              srgb;
        logic [NUM_CH-1:0] chan_mask;
    } t_flags;

    typedef logic [NUM_CH-1:0][LIN_BITS-1:0] t_avg_vec;
    typedef logic [NUM_CH-1:0][CH_W-1:0]     t_code_vec;
    typedef logic [255:0][LIN_BITS-1:0]      t_dec_table;

    // q30 fixed point: linear segment up to code 10, gamma segment through a fifth-root search of t^2
    function automatic t_dec_table build_decode_table();
        t_dec_table  tbl;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] p;
        logic [63:0] lin;
        logic [63:0] v;
        s = (64'd1 << LIN_BITS) - 64'd1;
        for (int i = 0; i < 256; i++) begin
            if (i <= 10) begin
                v = (64'd20 * s * 64'(i) + 64'd32946) / 64'd65892;
            end else begin
                t  = (64'(40 * i + 561) << 30) / 64'd10761;
                t2 = (t * t) >> 30;
                lo = 64'd0;
                hi = 64'd1 << 30;
                while (lo < hi) begin
                    mid = lo + ((hi - lo + 64'd1) >> 1);
                    p   = mid;
                    for (int k = 0; k < 4; k++) begin
                        p = (p * mid) >> 30;
                    end
                    if (p <= t2) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                lin = (t2 * lo) >> 30;
                v   = (lin * s + (64'd1 << 29)) >> 30;
            end
            tbl[i] = LIN_BITS'(v);
        end
        return tbl;
    endfunction

    localparam t_dec_table DECODE_TABLE = build_decode_table();

endpackage

`default_nettype wire

/* rtl/mipds_ram.sv */
// generic simple dual port ram, one write and one registered read port
`default_nettype none

module mipds_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 2048,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/mipds_enc_stage.sv */
// one bit of the srgb encode search, a pipeline stage with valid and stall
`default_nettype none

module mipds_enc_stage #(
    parameter int BIT = 7
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire mipds_pkg::t_avg_vec   i_avg,
    input  wire mipds_pkg::t_code_vec  i_code,
    input  wire mipds_pkg::t_flags     i_flags,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output mipds_pkg::t_avg_vec        o_avg,
    output mipds_pkg::t_code_vec       o_code,
    output mipds_pkg::t_flags          o_flags
);

    logic                 r_valid;
    mipds_pkg::t_avg_vec  r_avg;
    mipds_pkg::t_code_vec r_code;
    mipds_pkg::t_flags    r_flags;
    mipds_pkg::t_code_vec n_code;
    logic                 load;

    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    // keep the candidate bit when its table value still fits under the average
    always_comb begin
        logic [mipds_pkg::CH_W-1:0] cand;
        for (int c = 0; c < mipds_pkg::NUM_CH; c++) begin
            cand = i_code[c] | (mipds_pkg::CH_W'(1) << BIT);
            if (i_flags.srgb && (mipds_pkg::DECODE_TABLE[cand] <= i_avg[c])) begin
                n_code[c] = cand;
            end else begin
                n_code[c] = i_code[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_avg   <= i_avg;
            r_code  <= n_code;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_avg   = r_avg;
    assign o_code  = r_code;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

/* rtl/mip_box_downsample_2x2_top.sv */
// 2x2 box filter mipmap reducer: line store, decode, average and srgb encode pipeline
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+--------------------------------------
//  pixel in  | in  | i_valid / o_stall              | i_image_start, i_pix_c0..i_pix_c3
//  pixel out | out | o_valid / i_stall              | o_out_c0..o_out_c3, o_row_end,
//            |     |                                | o_image_end
//  config    | in  | i_cfg_wr_en                    | i_cfg_idx, i_cfg_data
//
// one fine pixel per clock while o_stall is low; a coarse pixel leaves the registered
// stages after the transaction that closes its 2x2 block: line store read, decode table,
// sum, then an 8 step encode search, one code bit per stage
// every stage holds under stall and bubbles collapse, so input keeps flowing while
// the output register waits; synchronous reset clears positions, config and valid
// bits; the line store needs no clearing pass
`default_nettype none

module mip_box_downsample_2x2_top #(
    parameter int MAX_FINE_WIDTH = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [mipds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mipds_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_image_start,
    input  wire logic [7:0]                      i_pix_c0,
    input  wire logic [7:0]                      i_pix_c1,
    input  wire logic [7:0]                      i_pix_c2,
    input  wire logic [7:0]                      i_pix_c3,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_out_c0,
    output logic [7:0]                           o_out_c1,
    output logic [7:0]                           o_out_c2,
    output logic [7:0]                           o_out_c3,
    output logic                                 o_row_end,
    output logic                                 o_image_end
);

    localparam int POS_W      = (MAX_FINE_WIDTH > 2) ? $clog2(MAX_FINE_WIDTH) : 1;
    localparam int WID_W      = POS_W + 1;
    localparam int EXT_W      = (WID_W > mipds_pkg::CFG_W) ? WID_W : mipds_pkg::CFG_W;
    localparam int PAIR_DEPTH = MAX_FINE_WIDTH / 2;
    localparam int ADDR_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int SUM_W      = mipds_pkg::LIN_BITS + 2;
    localparam int NCH        = mipds_pkg::NUM_CH;
    localparam int NENC       = mipds_pkg::ENC_STAGES;

    // configuration
    logic [mipds_pkg::CNT_W-1:0] r_channel_count;
    logic                        r_srgb_mode;
    logic [mipds_pkg::CFG_W-1:0] r_fine_width;
    logic [mipds_pkg::CFG_W-1:0] r_fine_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= mipds_pkg::CNT_W'(4);
            r_srgb_mode     <= 1'b0;
            r_fine_width    <= mipds_pkg::CFG_W'(2);
            r_fine_height   <= mipds_pkg::CFG_W'(2);
        end else if (i_cfg_wr_en) begin
            case (mipds_pkg::t_cfg_idx'(i_cfg_idx))
                mipds_pkg::CFG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[mipds_pkg::CNT_W-1:0];
                end
                mipds_pkg::CFG_SRGB_MODE: begin
                    r_srgb_mode <= i_cfg_data[0];
                end
                mipds_pkg::CFG_FINE_WIDTH: begin
                    r_fine_width <= i_cfg_data;
                end
                mipds_pkg::CFG_FINE_HEIGHT: begin
                    r_fine_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // clamped geometry and channel mask
    logic [WID_W-1:0]            w;
    logic [mipds_pkg::HGT_W-1:0] h;
    logic [NCH-1:0]              chan_mask;

    always_comb begin
        logic [EXT_W-1:0]            fw_ext;
        logic [mipds_pkg::CNT_W-1:0] nch;
        fw_ext = EXT_W'(r_fine_width);
        if (fw_ext < EXT_W'(2)) begin
            w = WID_W'(2);
        end else if (fw_ext > EXT_W'(MAX_FINE_WIDTH)) begin
            w = WID_W'(MAX_FINE_WIDTH);
        end else begin
            w = WID_W'(fw_ext);
        end
        if (r_fine_height < mipds_pkg::HGT_W'(2)) begin
            h = mipds_pkg::HGT_W'(2);
        end else if (r_fine_height > mipds_pkg::HGT_W'(mipds_pkg::MAX_FINE_HEIGHT)) begin
            h = mipds_pkg::HGT_W'(mipds_pkg::MAX_FINE_HEIGHT);
        end else begin
            h = r_fine_height;
        end
        if (r_channel_count < mipds_pkg::CNT_W'(1)) begin
            nch = mipds_pkg::CNT_W'(1);
        end else if (r_channel_count > mipds_pkg::CNT_W'(mipds_pkg::MAX_CHANNELS)) begin
            nch = mipds_pkg::CNT_W'(mipds_pkg::MAX_CHANNELS);
        end else begin
            nch = r_channel_count;
        end
        for (int c = 0; c < NCH; c++) begin
            chan_mask[c] = mipds_pkg::CNT_W'(c) < nch;
        end
    end

    // input position tracking
    logic [POS_W-1:0]             r_col;
    logic [mipds_pkg::ROW_W-1:0]  r_row;
    logic [mipds_pkg::PIX_W-1:0]  r_left;
    logic [POS_W-1:0]             n_col;
    logic [mipds_pkg::ROW_W-1:0]  n_row;
    logic [POS_W-1:0]             col_cur;
    logic [mipds_pkg::ROW_W-1:0]  row_cur;
    logic [mipds_pkg::PIX_W-1:0]  pix;
    logic                         accept;
    logic                         in_box;
    logic                         wr_pair;
    logic                         rd_pair;
    logic                         row_end;
    logic                         image_end;
    logic [ADDR_W-1:0]            slot;

    assign accept  = i_valid && !o_stall;
    assign pix     = {i_pix_c3, i_pix_c2, i_pix_c1, i_pix_c0};
    assign col_cur = i_image_start ? '0 : r_col;
    assign row_cur = i_image_start ? '0 : r_row;
    assign slot    = ADDR_W'(col_cur >> 1);

    always_comb begin
        logic [WID_W-1:0]            col_ext;
        logic [WID_W-1:0]            col_inc;
        logic [mipds_pkg::HGT_W-1:0] row_ext;
        logic [mipds_pkg::HGT_W-1:0] row_inc;
        col_ext = WID_W'(col_cur);
        col_inc = col_ext + WID_W'(1);
        row_ext = mipds_pkg::HGT_W'(row_cur);
        row_inc = row_ext + mipds_pkg::HGT_W'(1);
        in_box  = (col_ext < (w & ~WID_W'(1)))
               && (row_ext < (h & ~mipds_pkg::HGT_W'(1)));
        wr_pair   = accept && col_cur[0] && in_box && !row_cur[0];
        rd_pair   = accept && col_cur[0] && in_box && row_cur[0];
        row_end   = WID_W'(col_cur >> 1) == ((w >> 1) - WID_W'(1));
        image_end = row_end
                 && (mipds_pkg::HGT_W'(row_cur >> 1) == ((h >> 1) - mipds_pkg::HGT_W'(1)));
        // wrap column at the row end, and row at the image end or past a shrunk height
        if (col_inc >= w) begin
            n_col = '0;
            n_row = (row_inc >= h) ? '0 : mipds_pkg::ROW_W'(row_inc);
        end else begin
            n_col = POS_W'(col_inc);
            n_row = (row_ext >= h) ? '0 : row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_left <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!col_cur[0]) begin
                r_left <= pix;
            end
        end
    end

    // line store of even row pairs
    logic [mipds_pkg::PAIR_W-1:0] ram_rdata;

    mipds_ram #(
        .WIDTH (mipds_pkg::PAIR_W),
        .DEPTH (PAIR_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_pair),
        .i_waddr (slot),
        .i_wdata ({pix, r_left}),
        .i_re    (rd_pair),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    // stage 1: line store read in flight
    logic                        r1_valid;
    logic [mipds_pkg::PIX_W-1:0] r1_left;
    logic [mipds_pkg::PIX_W-1:0] r1_pix;
    mipds_pkg::t_flags           r1_flags;
    logic                        st1;
    logic                        st2;
    logic                        st3;
    logic [NENC:0]               enc_stall;

    assign st1     = r1_valid && st2;
    assign o_stall = st1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (!st1) begin
            r1_valid <= rd_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_pair) begin
            r1_left            <= r_left;
            r1_pix             <= pix;
            r1_flags.row_end   <= row_end;
            r1_flags.image_end <= image_end;
            r1_flags.srgb      <= r_srgb_mode;
            r1_flags.chan_mask <= chan_mask;
        end
    end

    // stage 2: per channel decode of the four pixels
    logic                                           r2_valid;
    logic [NCH-1:0][3:0][mipds_pkg::LIN_BITS-1:0]   r2_val;
    logic [NCH-1:0][3:0][mipds_pkg::LIN_BITS-1:0]   n2_val;
    mipds_pkg::t_flags                              r2_flags;

    assign st2 = r2_valid && st3;

    always_comb begin
        logic [3:0][mipds_pkg::PIX_W-1:0] src;
        logic [mipds_pkg::CH_W-1:0]       b;
        src[0] = ram_rdata[mipds_pkg::PIX_W-1:0];
        src[1] = ram_rdata[mipds_pkg::PAIR_W-1:mipds_pkg::PIX_W];
        src[2] = r1_left;
        src[3] = r1_pix;
        for (int c = 0; c < NCH; c++) begin
            for (int p = 0; p < 4; p++) begin
                b = src[p][c*mipds_pkg::CH_W +: mipds_pkg::CH_W];
                n2_val[c][p] = r1_flags.srgb ? mipds_pkg::DECODE_TABLE[b]
                                             : mipds_pkg::LIN_BITS'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (!st2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid && !st2) begin
            r2_val   <= n2_val;
            r2_flags <= r1_flags;
        end
    end

    // stage 3: floor average; in linear mode this is already the result code
    logic                 r3_valid;
    mipds_pkg::t_avg_vec  r3_avg;
    mipds_pkg::t_code_vec r3_code;
    mipds_pkg::t_flags    r3_flags;
    mipds_pkg::t_avg_vec  n3_avg;
    mipds_pkg::t_code_vec n3_code;

    assign st3 = r3_valid && enc_stall[0];

    always_comb begin
        logic [SUM_W-1:0] sum;
        for (int c = 0; c < NCH; c++) begin
            sum = SUM_W'(r2_val[c][0]) + SUM_W'(r2_val[c][1])
                + SUM_W'(r2_val[c][2]) + SUM_W'(r2_val[c][3]);
            n3_avg[c]  = sum[SUM_W-1:2];
            n3_code[c] = r2_flags.srgb ? '0 : sum[mipds_pkg::CH_W+1:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (!st3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid && !st3) begin
            r3_avg   <= n3_avg;
            r3_code  <= n3_code;
            r3_flags <= r2_flags;
        end
    end

    // encode search, most significant code bit first
    logic [NENC:0]          enc_valid;
    mipds_pkg::t_avg_vec    enc_avg   [NENC+1];
    mipds_pkg::t_code_vec   enc_code  [NENC+1];
    mipds_pkg::t_flags      enc_flags [NENC+1];

    assign enc_valid[0]    = r3_valid;
    assign enc_avg[0]      = r3_avg;
    assign enc_code[0]     = r3_code;
    assign enc_flags[0]    = r3_flags;
    assign enc_stall[NENC] = i_stall;

    for (genvar j = 0; j < NENC; j++) begin : g_enc
        mipds_enc_stage #(
            .BIT (NENC - 1 - j)
        ) u_enc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (enc_valid[j]),
            .o_stall (enc_stall[j]),
            .i_avg   (enc_avg[j]),
            .i_code  (enc_code[j]),
            .i_flags (enc_flags[j]),
            .o_valid (enc_valid[j+1]),
            .i_stall (enc_stall[j+1]),
            .o_avg   (enc_avg[j+1]),
            .o_code  (enc_code[j+1]),
            .o_flags (enc_flags[j+1])
        );
    end

    // last encode stage is the output register
    mipds_pkg::t_code_vec out_code;
    mipds_pkg::t_flags    out_flags;

    assign out_flags = enc_flags[NENC];

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            out_code[c] = out_flags.chan_mask[c] ? enc_code[NENC][c] : '0;
        end
    end

    assign o_valid     = enc_valid[NENC];
    assign o_out_c0    = out_code[0];
    assign o_out_c1    = out_code[1];
    assign o_out_c2    = out_code[2];
    assign o_out_c3    = out_code[3];
    assign o_row_end   = out_flags.row_end;
    assign o_image_end = out_flags.image_end;

endmodule

`default_nettype wire

/* dv/mip_box_downsample_2x2_top_tb.sv */
// testbench for the 2x2 mipmap reducer: directed and random images scored against a predictor
module mip_box_downsample_2x2_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_SLOTS    = 2048;
    localparam int WIDTH_CAP     = 4096;
    localparam int HEIGHT_CAP    = 4096;
    localparam int CHANNEL_CAP   = 4;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int RANDOM_ITEMS  = 590;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_GAP       = 6;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        logic [3:0][7:0] chan;
        logic            row_end;
        logic            image_end;
    } t_coarse_pix;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [mipds_pkg::CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [mipds_pkg::CFG_W-1:0]     i_cfg_data    = '0;
    logic                            i_valid       = 1'b0;
    logic                            i_image_start = 1'b0;
    logic [7:0]                      i_pix_c0      = '0;
    logic [7:0]                      i_pix_c1      = '0;
    logic [7:0]                      i_pix_c2      = '0;
    logic [7:0]                      i_pix_c3      = '0;
    logic                            i_stall       = 1'b0;
    logic                            o_stall;
    logic                            o_valid;
    logic [7:0]                      o_out_c0;
    logic [7:0]                      o_out_c1;
    logic [7:0]                      o_out_c2;
    logic [7:0]                      o_out_c3;
    logic                            o_row_end;
    logic                            o_image_end;

    mip_box_downsample_2x2_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_image_start (i_image_start),
        .i_pix_c0      (i_pix_c0),
        .i_pix_c1      (i_pix_c1),
        .i_pix_c2      (i_pix_c2),
        .i_pix_c3      (i_pix_c3),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_c0      (o_out_c0),
        .o_out_c1      (o_out_c1),
        .o_out_c2      (o_out_c2),
        .o_out_c3      (o_out_c3),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end)
    );

    // predictor copy of the block state and registers
    logic [15:0]   lin_table [256];
    logic [63:0]   line_store [LINE_SLOTS];
    logic [31:0]   held_left    = '0;
    int unsigned   col_pos      = 0;
    int unsigned   row_pos      = 0;
    int unsigned   cfg_channels = 4;
    int unsigned   cfg_srgb     = 0;
    int unsigned   cfg_width    = 2;
    int unsigned   cfg_height   = 2;
    t_coarse_pix   coarse_q [$];

    int            fail_count   = 0;
    int            cycle_count  = 0;
    int            burst_left   = 0;
    int            gap_len      = 0;
    bit            no_gaps      = 1'b0;
    bit            long_hold_go = 1'b0;
    int            hold_count   = 0;
    t_stall_mode   stall_mode   = STALL_NONE;
    int            mode_left    = 0;
    int            stall_phase  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned q30_fifth_power(longint unsigned r);
        longint unsigned p;
        p = r;
        repeat (4) p = (p * r) >> 30;
        return p;
    endfunction

    // linear up to code 10; above it a q30 gamma curve: t^2.4 found as t^2 times the fifth root of t^2
    function automatic void build_lin_table();
        longint unsigned s;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned lin;
        longint unsigned v;
        s = (64'd1 << 16) - 64'd1;
        for (int i = 0; i < 256; i++) begin
            if (i <= 10) begin
                v = (64'd20 * s * longint'(i) + 64'd32946) / 64'd65892;
            end else begin
                t  = (longint'(40 * i + 561) << 30) / 64'd10761;
                t2 = (t * t) >> 30;
                lo = 0;
                hi = 64'd1 << 30;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 64'd1) / 64'd2;
                    if (q30_fifth_power(mid) <= t2) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
                lin = (t2 * lo) >> 30;
                v   = (lin * s + (64'd1 << 29)) >> 30;
            end
            lin_table[i] = v[15:0];
        end
    endfunction

    function automatic logic [7:0] srgb_encode(int unsigned avg);
        for (int k = 255; k > 0; k--) begin
            if (lin_table[k] <= avg) return 8'(k);
        end
        return 8'd0;
    endfunction

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // advance the predictor by one accepted fine pixel
    function automatic void predict_coarse(logic start, logic [31:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned nch;
        int unsigned cw;
        int unsigned chh;
        int unsigned col;
        int unsigned row;
        int unsigned slot;
        int unsigned sum;
        logic [31:0] up_l;
        logic [31:0] up_r;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  d;
        logic [7:0]  e;
        t_coarse_pix res;
        w   = clamp_u(cfg_width, 2, WIDTH_CAP);
        h   = clamp_u(cfg_height, 2, HEIGHT_CAP);
        nch = clamp_u(cfg_channels, 1, CHANNEL_CAP);
        cw  = w / 2;
        chh = h / 2;
        if (start) begin
            col_pos = 0;
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        if (col % 2 == 0) begin
            held_left = pix;
        end else if (col < 2 * cw && row < 2 * chh) begin
            slot = (col / 2) % LINE_SLOTS;
            if (row % 2 == 0) begin
                line_store[slot] = {pix, held_left};
            end else begin
                up_l = line_store[slot][31:0];
                up_r = line_store[slot][63:32];
                for (int c = 0; c < 4; c++) begin
                    a = up_l[8*c +: 8];
                    b = up_r[8*c +: 8];
                    d = held_left[8*c +: 8];
                    e = pix[8*c +: 8];
                    res.chan[c] = 8'd0;
                    if (c < nch) begin
                        if (cfg_srgb != 0) begin
                            sum = lin_table[a] + lin_table[b] + lin_table[d] + lin_table[e];
                            res.chan[c] = srgb_encode(sum / 4);
                        end else begin
                            sum = a + b + d + e;
                            res.chan[c] = 8'(sum / 4);
                        end
                    end
                end
                res.row_end   = (col / 2 == cw - 1);
                res.image_end = res.row_end && (row / 2 == chh - 1);
                coarse_q.push_back(res);
            end
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end else if (row >= h) begin
            row = 0;
        end
        col_pos = col;
        row_pos = row;
    endfunction

    // entered and left just after a rising edge
    task automatic send_pixel(input logic start, input logic [31:0] pix);
        if (!no_gaps && burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap_len > 0) begin
                i_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        i_valid       <= 1'b1;
        i_image_start <= start;
        i_pix_c0      <= pix[7:0];
        i_pix_c1      <= pix[15:8];
        i_pix_c2      <= pix[23:16];
        i_pix_c3      <= pix[31:24];
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_coarse(start, pix);
    endtask

    task automatic send_image(input int npix, input bit lead_start, input bit noisy,
                              output int sent_n);
        logic start;
        bit   cut;
        sent_n = 0;
        cut    = 1'b0;
        while (sent_n < npix && !cut) begin
            // broken images: cut short, or restarted in the middle
            if (noisy && sent_n > 0 && $urandom_range(0, 299) == 0) begin
                cut = 1'b1;
            end else begin
                start = (sent_n == 0 && lead_start) ||
                        (noisy && sent_n > 0 && $urandom_range(0, 199) == 0);
                send_pixel(start, {rand_chan(), rand_chan(), rand_chan(), rand_chan()});
                sent_n++;
            end
        end
    endtask

    task automatic put_reg(input mipds_pkg::t_cfg_idx idx, input int unsigned val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= mipds_pkg::CFG_W'(val);
        @(posedge i_clk);
        case (idx)
            mipds_pkg::CFG_CHANNEL_COUNT: cfg_channels = val & 32'h7;
            mipds_pkg::CFG_SRGB_MODE:     cfg_srgb     = val & 32'h1;
            mipds_pkg::CFG_FINE_WIDTH:    cfg_width    = val & 32'h1FFF;
            mipds_pkg::CFG_FINE_HEIGHT:   cfg_height   = val & 32'h1FFF;
            default: begin
            end
        endcase
    endtask

    task automatic load_config(input int unsigned nch, input int unsigned srgb,
                               input int unsigned w, input int unsigned h);
        put_reg(mipds_pkg::CFG_CHANNEL_COUNT, nch);
        put_reg(mipds_pkg::CFG_SRGB_MODE, srgb);
        put_reg(mipds_pkg::CFG_FINE_WIDTH, w);
        put_reg(mipds_pkg::CFG_FINE_HEIGHT, h);
        i_cfg_wr_en <= 1'b0;
    endtask

    // a pixel may be in flight with no coarse result, so settle past the pipeline depth
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (coarse_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_linear_extremes();
        wait_idle();
        // channel count above range acts as four
        load_config(7, 0, 2, 2);
        send_pixel(1'b1, {8'hFF, 8'h00, 8'hFF, 8'h00});
        send_pixel(1'b0, {8'h00, 8'hFF, 8'h00, 8'hFF});
        send_pixel(1'b0, 32'hFFFF_FFFF);
        send_pixel(1'b0, 32'h0000_0000);
        // second image follows by position wrap alone
        repeat (4) send_pixel(1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_srgb_codes();
        wait_idle();
        // channel count zero keeps channel 0 only
        load_config(0, 1, 2, 2);
        send_pixel(1'b1, {8'd255, 8'd11, 8'd10, 8'd0});
        send_pixel(1'b0, {8'd10, 8'd0, 8'd255, 8'd10});
        send_pixel(1'b0, {8'd0, 8'd255, 8'd11, 8'd11});
        send_pixel(1'b0, {8'd11, 8'd10, 8'd0, 8'd255});
    endtask

    task automatic test_odd_trailing();
        int n;
        wait_idle();
        load_config(2, 0, 3, 3);
        send_image(9, 1'b1, 1'b0, n);
        wait_idle();
        // width and height below range act as two
        load_config(1, 0, 1, 0);
        send_image(4, 1'b1, 1'b0, n);
    endtask

    task automatic test_width_shrink();
        wait_idle();
        load_config(4, 0, 8, 4);
        send_pixel(1'b1, {rand_chan(), rand_chan(), rand_chan(), rand_chan()});
        repeat (3) send_pixel(1'b0, {rand_chan(), rand_chan(), rand_chan(), rand_chan()});
        wait_idle();
        // column now past the new width: dropped, then wraps into row one
        load_config(4, 0, 0, 4);
        repeat (3) send_pixel(1'b0, {rand_chan(), rand_chan(), rand_chan(), rand_chan()});
    endtask

    task automatic test_size_extremes();
        int n;
        wait_idle();
        // width above range acts as the maximum: no row wrap within the first pixels
        load_config(4, 1, 8191, 1);
        send_image(96, 1'b1, 1'b0, n);
        wait_idle();
        // height above range acts as the maximum: rows keep counting past small sizes
        load_config(3, 0, 1, 8191);
        send_image(96, 1'b1, 1'b0, n);
    endtask

    task automatic test_input_backpressure();
        int n;
        wait_idle();
        load_config(4, 1, 6, 4);
        long_hold_go = 1'b1;
        no_gaps      = 1'b1;
        send_image(240, 1'b1, 1'b0, n);
        no_gaps      = 1'b0;
    endtask

    task automatic test_random_images();
        int          sent;
        int          n;
        int          imgs;
        int unsigned w;
        int unsigned h;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
            load_config($urandom_range(0, 7), $urandom_range(0, 1), w, h);
            imgs = $urandom_range(1, 3);
            for (int k = 0; k < imgs; k++) begin
                send_image(clamp_u(w, 2, WIDTH_CAP) * clamp_u(h, 2, HEIGHT_CAP),
                           (k == 0) || ($urandom_range(0, 3) == 0), 1'b1, n);
                sent += n;
            end
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (long_hold_go && hold_count < LONG_HOLD) begin
            hold_count++;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(16, 160);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                STALL_NONE:     i_stall <= 1'b0;
                STALL_SPARSE:   i_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_stall <= (stall_phase % 5 < 2);
                default:        i_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // score every coarse pixel transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_coarse_pix got;
        t_coarse_pix want;
        logic [7:0]  got_f [6];
        logic [7:0]  want_f [6];
        string       field_name [6];
        field_name = '{"c0", "c1", "c2", "c3", "row_end", "image_end"};
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            got.chan      = {o_out_c3, o_out_c2, o_out_c1, o_out_c0};
            got.row_end   = o_row_end;
            got.image_end = o_image_end;
            if (coarse_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected coarse pixel: expected none, actual %h",
                         $time, got);
            end else begin
                want = coarse_q.pop_front();
                for (int k = 0; k < 4; k++) begin
                    got_f[k]  = got.chan[k];
                    want_f[k] = want.chan[k];
                end
                got_f[4]  = {7'd0, got.row_end};
                want_f[4] = {7'd0, want.row_end};
                got_f[5]  = {7'd0, got.image_end};
                want_f[5] = {7'd0, want.image_end};
                for (int k = 0; k < 6; k++) begin
                    if (got_f[k] !== want_f[k]) begin
                        fail_count++;
                        $display("%0t: %s mismatch: expected %0d, actual %0d",
                                 $time, field_name[k], want_f[k], got_f[k]);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("mip_box_downsample_2x2_top regression: fail");
        $finish;
    end

    initial begin
        build_lin_table();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_linear_extremes();
        test_srgb_codes();
        test_odd_trailing();
        test_width_shrink();
        test_size_extremes();
        test_input_backpressure();
        test_random_images();
        wait_idle();
        if (fail_count == 0) begin
            $display("mip_box_downsample_2x2_top regression: pass");
        end else begin
            $display("mip_box_downsample_2x2_top regression: fail");
        end
        $finish;
    end

endmodule
